// ----- design/psd_pkg.sv -----
// Shared widths, shape codes and pipeline types for the signed distance block.
package psd_pkg;

    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int OUT_W    = 18;
    localparam int SQ_W     = 32;
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] KIND_SPHERE   = 2'd0;
    localparam logic [1:0] KIND_CYLINDER = 2'd1;
    localparam logic [1:0] KIND_BOX      = 2'd2;
    localparam logic [1:0] KIND_TORUS    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_A     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_B     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_C     = 2'd3;

    typedef struct packed {
        logic signed [OUT_W-1:0] box_d;
        logic signed [OUT_W-1:0] z_term;
        logic [SQ_W-1:0]         sq_z;
    } side_t;

endpackage

// ----- design/psd_isqrt.sv -----
// Pipelined floor integer square root, one result bit per register stage.
module psd_isqrt
    import psd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   n,
    output logic [ROOT_W-1:0] root
);

    logic [ROOT_W+3:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] res_reg  [ROOT_W];
    logic [SQ_W-1:0]   n_reg    [ROOT_W];
    logic [ROOT_W+3:0] rem_next [ROOT_W];
    logic [ROOT_W-1:0] res_next [ROOT_W];
    logic [SQ_W-1:0]   n_next   [ROOT_W];

    always_comb
    begin
        logic [ROOT_W+3:0] rem_in;
        logic [ROOT_W-1:0] res_in;
        logic [SQ_W-1:0]   n_in;
        logic [ROOT_W+3:0] rem_sh;
        logic [ROOT_W+3:0] trial;
        for (int i = 0; i < ROOT_W; i++)
        begin
            rem_in = (i == 0) ? '0 : rem_reg[(i == 0) ? 0 : i-1];
            res_in = (i == 0) ? '0 : res_reg[(i == 0) ? 0 : i-1];
            n_in   = (i == 0) ? n  : n_reg[(i == 0) ? 0 : i-1];
            rem_sh = {rem_in[ROOT_W+1:0], n_in[SQ_W-1 -: 2]};
            trial  = {2'b00, res_in, 2'b01};
            n_next[i] = {n_in[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next[i] = rem_sh - trial;
                res_next[i] = {res_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem_sh;
                res_next[i] = {res_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                res_reg[i] <= res_next[i];
                n_reg[i]   <= n_next[i];
            end
        end
    end

    assign root = res_reg[ROOT_W-1];

endmodule

// ----- design/primitive_signed_distance.sv -----
// Top level of the signed distance pipeline for sphere, cylinder, box and torus.
// Usage: each input word is a point (px, py, pz) in signed Q8; each output word
// is the signed distance to the configured primitive, negative inside.
// The input and output channels use valid and ready. One point enters per cycle
// and one result leaves per cycle while the receiver does not stall. The depth
// is set by two 16-stage square root pipelines in series, which the torus needs,
// plus the absolute value, square, sum, radius and output registers.
// The configuration port writes shape_kind, size_a, size_b and size_c by index;
// the user must write it only while the pipeline is empty; the block does not enforce it.
// At reset all valid bits clear, the shape is a sphere and every size is 256.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and in_ready drops, so no word is lost or repeated.
module primitive_signed_distance
    import psd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_W-1:0]   px,
    input  logic signed [COORD_W-1:0]   py,
    input  logic signed [COORD_W-1:0]   pz,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [OUT_W-1:0]     signed_distance,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [SIZE_W-1:0]           cfg_data
);

    localparam int NSTAGE   = 2*ROOT_W + 7;
    localparam int SIDE_DLY = 2*ROOT_W + 4;
    localparam int RAD_DLY  = ROOT_W + 2;
    localparam int SQZ_TAP  = ROOT_W + 2;

    logic [1:0]        kind_reg;
    logic [SIZE_W-1:0] size_a_reg;
    logic [SIZE_W-1:0] size_b_reg;
    logic [SIZE_W-1:0] size_c_reg;

    logic [NSTAGE-1:0] vld_reg;
    logic              en;

    logic [COORD_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    side_t              side_reg;
    side_t              side_next;
    side_t              side_dly [SIDE_DLY];
    logic [SQ_W-1:0]    sum1_reg;
    logic [ROOT_W-1:0]  root1, root2;
    logic signed [RAD_W-1:0] rad_reg;
    logic signed [RAD_W-1:0] rad_dly [RAD_DLY];
    logic [SQ_W-1:0]    rsq_reg;
    logic [SQ_W-1:0]    sum2_reg;
    logic signed [OUT_W-1:0] dist_reg, dist_next;
    logic [RAD_W-1:0]   rad_mag;

    assign en        = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTAGE-1];
    assign signed_distance = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_SPHERE;
            size_a_reg <= SIZE_W'(256);
            size_b_reg <= SIZE_W'(256);
            size_c_reg <= SIZE_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHAPE_KIND: kind_reg   <= cfg_data[1:0];
                REG_SIZE_A:     size_a_reg <= cfg_data;
                REG_SIZE_B:     size_b_reg <= cfg_data;
                REG_SIZE_C:     size_c_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
    end

    always_comb
    begin
        logic signed [OUT_W-1:0] dx, dy, dz, mxy;
        dx = $signed({2'b00, ax_reg}) - $signed({4'b0000, size_a_reg[SIZE_W-1:1]});
        dy = $signed({2'b00, ay_reg}) - $signed({4'b0000, size_b_reg[SIZE_W-1:1]});
        dz = $signed({2'b00, az_reg}) - $signed({4'b0000, size_c_reg[SIZE_W-1:1]});
        mxy = (dx > dy) ? dx : dy;
        side_next.box_d  = (mxy > dz) ? mxy : dz;
        side_next.z_term = $signed({2'b00, az_reg})
                         - $signed({4'b0000, size_b_reg[SIZE_W-1:1]});
        side_next.sq_z   = {{(SQ_W-COORD_W){1'b0}}, az_reg}
                         * {{(SQ_W-COORD_W){1'b0}}, az_reg};
    end

    assign rad_mag = rad_reg[RAD_W-1] ? RAD_W'(-rad_reg) : RAD_W'(rad_reg);

    always_comb
    begin
        logic signed [OUT_W-1:0] rad_w, cyl;
        rad_w = OUT_W'(rad_dly[RAD_DLY-1]);
        cyl   = (rad_w > side_dly[SIDE_DLY-1].z_term) ? rad_w : side_dly[SIDE_DLY-1].z_term;
        case (kind_reg)
            KIND_SPHERE:   dist_next = rad_w;
            KIND_CYLINDER: dist_next = cyl;
            KIND_BOX:      dist_next = side_dly[SIDE_DLY-1].box_d;
            default:       dist_next = $signed({2'b00, root2})
                                     - $signed({3'b000, size_b_reg});
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= px[COORD_W-1] ? COORD_W'(-px) : COORD_W'(px);
            ay_reg   <= py[COORD_W-1] ? COORD_W'(-py) : COORD_W'(py);
            az_reg   <= pz[COORD_W-1] ? COORD_W'(-pz) : COORD_W'(pz);
            sqx_reg  <= {{(SQ_W-COORD_W){1'b0}}, ax_reg} * {{(SQ_W-COORD_W){1'b0}}, ax_reg};
            sqy_reg  <= {{(SQ_W-COORD_W){1'b0}}, ay_reg} * {{(SQ_W-COORD_W){1'b0}}, ay_reg};
            side_reg <= side_next;
            sum1_reg <= (kind_reg == KIND_SPHERE) ? sqx_reg + sqy_reg + side_reg.sq_z
                                                  : sqx_reg + sqy_reg;
            side_dly[0] <= side_reg;
            for (int i = 1; i < SIDE_DLY; i++)
                side_dly[i] <= side_dly[i-1];
            rad_reg  <= $signed({1'b0, root1}) - $signed({2'b00, size_a_reg});
            rad_dly[0] <= rad_reg;
            for (int i = 1; i < RAD_DLY; i++)
                rad_dly[i] <= rad_dly[i-1];
            rsq_reg  <= {{(SQ_W-RAD_W){1'b0}}, rad_mag} * {{(SQ_W-RAD_W){1'b0}}, rad_mag};
            sum2_reg <= rsq_reg + side_dly[SQZ_TAP].sq_z;
            dist_reg <= dist_next;
        end
    end

    psd_isqrt u_root1
    (
        .clk  (clk),
        .en   (en),
        .n    (sum1_reg),
        .root (root1)
    );

    psd_isqrt u_root2
    (
        .clk  (clk),
        .en   (en),
        .n    (sum2_reg),
        .root (root2)
    );

endmodule

// ----- sim/primitive_signed_distance_tb.sv -----
// Self-checking testbench for the signed distance pipeline with random stimulus and stalls.
module primitive_signed_distance_tb
    import psd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 38;
    localparam int CYCLE_LIMIT = 400000;

    class distance_scoreboard;
        logic [1:0] kind;
        int unsigned len_a;
        int unsigned len_b;
        int unsigned len_c;
        logic signed [OUT_W-1:0] pending_distances[$];
        int mismatches;

        function new();
            kind = KIND_SPHERE;
            len_a = 256;
            len_b = 256;
            len_c = 256;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
            case (idx)
                REG_SHAPE_KIND: kind = value[1:0];
                REG_SIZE_A:     len_a = value;
                REG_SIZE_B:     len_b = value;
                REG_SIZE_C:     len_c = value;
                default: ;
            endcase
        endfunction

        function longint isqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bit_w;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > n)
                bit_w = bit_w >> 2;
            while (bit_w != 0)
            begin
                if (n >= res + bit_w)
                begin
                    n = n - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                    res = res >> 1;
                bit_w = bit_w >> 2;
            end
            return longint'(res);
        endfunction

        function longint absval(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic signed [COORD_W-1:0] z);
            longint vx;
            longint vy;
            longint vz;
            longint d;
            longint radial;
            longint t;
            vx = x;
            vy = y;
            vz = z;
            case (kind)
                KIND_SPHERE:
                    d = isqrt(vx * vx + vy * vy + vz * vz) - len_a;
                KIND_CYLINDER:
                begin
                    radial = isqrt(vx * vx + vy * vy) - len_a;
                    t = absval(vz) - (len_b >> 1);
                    d = (radial > t) ? radial : t;
                end
                KIND_BOX:
                begin
                    d = absval(vx) - (len_a >> 1);
                    t = absval(vy) - (len_b >> 1);
                    if (t > d)
                        d = t;
                    t = absval(vz) - (len_c >> 1);
                    if (t > d)
                        d = t;
                end
                default:
                begin
                    radial = isqrt(vx * vx + vy * vy) - len_a;
                    d = isqrt(radial * radial + vz * vz) - len_b;
                end
            endcase
            pending_distances.push_back(d[OUT_W-1:0]);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_distance(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (pending_distances.size() == 0)
                report($sformatf("unexpected word %0d", got));
            else
            begin
                want = pending_distances.pop_front();
                if (got !== want)
                    report($sformatf("signed_distance got %0d want %0d", got, want));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_W-1:0] signed_distance;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    distance_scoreboard board;
    bit quiet_phase;
    bit hold_off;
    int cycle_count = 0;

    primitive_signed_distance i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .px(px), .py(py), .pz(pz),
        .out_valid(out_valid), .out_ready(out_ready),
        .signed_distance(signed_distance),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_distance(signed_distance);
    end

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        board.set_register(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                    logic signed [COORD_W-1:0] z);
        if (!quiet_phase && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1'b1;
        px <= x;
        py <= y;
        pz <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_point(x, y, z);
        @(negedge clk);
    endtask

    task drain;
        in_valid <= 1'b0;
        while (board.pending_distances.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    function logic signed [COORD_W-1:0] random_coord(int scale);
        case ($urandom_range(0, 3))
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed(16'($urandom_range(0, 2 * scale))) - scale);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return COORD_W'($signed(16'($urandom_range(0, 2048))) - 1024);
        endcase
    endfunction

    task random_phase(int count);
        int i;
        int scale;
        scale = 1 + int'(board.len_a + board.len_b + board.len_c);
        if (scale > 32767)
            scale = 32767;
        for (i = 0; i < count; i++)
            send_point(random_coord(scale), random_coord(scale), random_coord(scale));
    endtask

    initial
    begin
        int phase;
        int k;
        board = new();
        in_valid = 1'b0;
        px = '0;
        py = '0;
        pz = '0;
        cfg_we = 1'b0;
        cfg_index = REG_SHAPE_KIND;
        cfg_data = '0;
        quiet_phase = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < 4; k++)
        begin
            write_register(REG_SHAPE_KIND, 15'(k) | 15'h7ffc & 15'h0000);
            send_point(16'sh0000, 16'sh0000, 16'sh0000);
            send_point(16'sh8000, 16'sh8000, 16'sh8000);
            send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
            send_point(16'sh8000, 16'sh7fff, 16'sh0100);
            send_point(16'sh0080, -16'sh0100, 16'sh0080);
            drain();
        end
        write_register(REG_SIZE_A, 15'h7fff);
        write_register(REG_SIZE_B, 15'h0001);
        write_register(REG_SIZE_C, 15'h0000);
        write_register(REG_SHAPE_KIND, KIND_BOX);
        send_point(16'sh8000, 16'sh0000, 16'sh0001);
        send_point(16'sh4000, 16'sh8000, 16'sh7fff);
        drain();

        for (phase = 0; phase < 12; phase++)
        begin
            write_register(REG_SHAPE_KIND, 15'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: write_register(REG_SIZE_A, 15'h7fff);
                1: write_register(REG_SIZE_A, 15'h0000);
                default: write_register(REG_SIZE_A, 15'($urandom_range(0, 4096)));
            endcase
            write_register(REG_SIZE_B, $urandom_range(0, 1) ? 15'($urandom) :
                                        15'($urandom_range(0, 2048)));
            write_register(REG_SIZE_C, 15'($urandom));
            if (phase == 3)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (200) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (phase >= 10)
                quiet_phase = 1'b1;
            random_phase(150);
            drain();
        end
        if (board.mismatches == 0 && board.pending_distances.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/psd_pkg.sv
design/psd_isqrt.sv
design/primitive_signed_distance.sv
sim/primitive_signed_distance_tb.sv
